// ===== rtl/sha256_stream_hasher_top_macros.svh =====
// ---------------------------------------------------------------------------
// sha256_stream_hasher_top_macros.svh
// Assertion shorthands shared by the hasher checker.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Clocked on clock, held off while reset is high.
`define SHA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same, for an implication whose consequent is checked in the next cycle.
`define SHA_ASSERT_NEXT(label, pre, post, msg) \
   `SHA_ASSERT(label, (pre) |=> (post), msg)

`endif

// ===== rtl/sha_pkg.sv =====
// ---------------------------------------------------------------------------
// sha_pkg
// Types, constants and tables shared by the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [7:0][31:0] hash_set_type;

   // Input beat: one byte or a finish request.
   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_type;

   // Output beat: one digest word.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   localparam logic [5:0] BLOCK_LAST  = 6'd63;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [5:0] ROUND_LAST  = 6'd63;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [7:0] ZERO_BYTE   = 8'h00;
   localparam logic [2:0] DIGEST_LAST = 3'd7;

   // Control from the sequencer to the message schedule.
   typedef struct packed {
      logic        put_byte;
      logic        put_len;
      logic        shift;
      logic [5:0]  pos;
      logic [7:0]  data;
      logic [60:0] count;
   } sched_ctl_type;

   // Control from the sequencer to the round core.
   typedef struct packed {
      logic init_h;
      logic load;
      logic round;
      logic add;
   } core_ctl_type;

   // H7 first so that element k holds Hk.
   localparam hash_set_type HASH_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

// ===== rtl/sha_sched.sv =====
// ---------------------------------------------------------------------------
// sha_sched
// 16-word message block store and rolling message schedule.
// ---------------------------------------------------------------------------
`default_nettype none

module sha_sched (
   input  wire logic                   clock,
   input  wire sha_pkg::sched_ctl_type ctl,
   output sha_pkg::word_type           w_out
);
   import sha_pkg::*;

   word_type w_ff [16];
   word_type w_in [16];

   function automatic word_type sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   always_comb begin
      logic [3:0] wsel;
      logic [1:0] lane;
      word_type   next_w;
      wsel   = ctl.pos[5:2];
      lane   = ctl.pos[1:0];
      next_w = sig1(w_ff[14]) + w_ff[9] + sig0(w_ff[1]) + w_ff[0];
      w_in   = w_ff;
      if (ctl.shift) begin
         // w[0] always holds the word of the current round
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15] = next_w;
      end else if (ctl.put_len) begin
         w_in[14] = ctl.count[60:29];
         w_in[15] = {ctl.count[28:0], 3'b000};
      end else if (ctl.put_byte) begin
         // bytes of a word arrive in order; the first one clears the rest
         case (lane)
            2'd0:    w_in[wsel]        = {ctl.data, 24'h000000};
            2'd1:    w_in[wsel][23:16] = ctl.data;
            2'd2:    w_in[wsel][15:8]  = ctl.data;
            default: w_in[wsel][7:0]   = ctl.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   assign w_out = w_ff[0];

endmodule

`default_nettype wire

// ===== rtl/sha_core.sv =====
// ---------------------------------------------------------------------------
// sha_core
// Shared round unit: working variables a..h, hash words and add-back.
// ---------------------------------------------------------------------------
`default_nettype none

module sha_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sha_pkg::core_ctl_type ctl,
   input  wire logic [5:0]            round_idx,
   input  wire sha_pkg::word_type     w,
   output sha_pkg::hash_set_type      hash
);
   import sha_pkg::*;

   hash_set_type hash_ff, hash_in;
   hash_set_type var_ff, var_in;   // element 0 is a, element 7 is h

   always_comb begin
      word_type a, b, c, e, f, g, h;
      word_type s0, s1, ch, maj, t1, t2;
      a   = var_ff[0];
      b   = var_ff[1];
      c   = var_ff[2];
      e   = var_ff[4];
      f   = var_ff[5];
      g   = var_ff[6];
      h   = var_ff[7];
      s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
      ch  = g ^ (e & (f ^ g));
      t1  = h + s1 + ch + ROUND_K[round_idx] + w;
      s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
      maj = (a & b) | (c & (a | b));
      t2  = s0 + maj;

      var_in = var_ff;
      if (ctl.load) begin
         var_in = hash_ff;
      end else if (ctl.round) begin
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
      end

      hash_in = hash_ff;
      if (ctl.add) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + var_ff[i];
         end
      end else if (ctl.init_h) begin
         hash_in = HASH_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_INIT;
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
   end

   assign hash = hash_ff;

endmodule

`default_nettype wire

// ===== rtl/sha256_stream_hasher_top.sv =====
// Absorb beat: one byte; a beat that fills the block adds load, 64 rounds and add.
// Finish beat: padding writes one byte per cycle up to offset 56, then the length,
//   then one compression (two when fewer than 8 bytes remain), then 8 digest beats.
// Sustained rate is set by the single shared round unit; input stalls while it runs.
// Synchronous active-high reset loads the initial hash values and clears counters;
// no clearing pass is needed and the block is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream with iterative round core and small sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sha_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sha_pkg::rsp_type      rsp_data
);
   import sha_pkg::*;

   // Sequencer state.
   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;        // byte offset in current block
   logic [60:0] count_ff, count_in;      // message length in bytes, saturating
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;          // digest word being sent
   logic        pad_ff, pad_in;          // finishing a message
   logic        last_blk_ff, last_blk_in; // current compression is the final one

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        rsp_load;

   sched_ctl_type sched_ctl;
   core_ctl_type  core_ctl;
   word_type      sched_w;
   hash_set_type  hash;

   sha_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_out (sched_w)
   );

   sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (core_ctl),
      .round_idx (round_ff),
      .w         (sched_w),
      .hash      (hash)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (fill_ff == BLOCK_LAST) begin
                  state_in = ST_LOAD;            // this beat completes a block
               end else if (req_data.action == ACT_FINISH) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == LEN_POS || fill_ff == BLOCK_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (last_blk_ff) begin
               state_in = ST_EMIT;
            end else if (pad_ff) begin
               state_in = ST_PAD;                // extra block done, keep padding
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_load && idx_ff == DIGEST_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs and counter updates.
   always_comb begin
      req_stall   = 1'b1;
      sched_ctl   = '0;
      core_ctl    = '0;
      rsp_load    = 1'b0;
      fill_in     = fill_ff;
      count_in    = count_ff;
      round_in    = round_ff;
      idx_in      = idx_ff;
      pad_in      = pad_ff;
      last_blk_in = last_blk_ff;
      sched_ctl.pos = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               sched_ctl.put_byte = 1'b1;
               sched_ctl.data     = (req_data.action == ACT_FINISH) ? PAD_BYTE
                                                                    : req_data.data_byte;
               fill_in     = fill_ff + 6'd1;     // wraps to 0 at end of block
               pad_in      = req_data.action;
               last_blk_in = 1'b0;
               if (req_data.action == ACT_ABSORB && !(&count_ff)) begin
                  count_in = count_ff + 61'd1;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == LEN_POS) begin
               // bit length goes into the last two words
               sched_ctl.put_len = 1'b1;
               sched_ctl.count   = count_ff;
               count_in    = '0;
               fill_in     = '0;
               last_blk_in = 1'b1;
            end else begin
               sched_ctl.put_byte = 1'b1;
               sched_ctl.data     = ZERO_BYTE;
               fill_in            = fill_ff + 6'd1;
            end
         end
         ST_LOAD: begin
            core_ctl.load = 1'b1;
            round_in      = '0;
         end
         ST_ROUND: begin
            core_ctl.round  = 1'b1;
            sched_ctl.shift = 1'b1;
            round_in        = round_ff + 6'd1;
         end
         ST_ADD: begin
            core_ctl.add = 1'b1;
         end
         ST_EMIT: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
            if (rsp_load) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == DIGEST_LAST) begin
                  // last digest word loaded into the output register: restart for the next message
                  core_ctl.init_h = 1'b1;
                  pad_in          = 1'b0;
                  last_blk_in     = 1'b0;
               end
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         count_ff    <= '0;
         round_ff    <= '0;
         idx_ff      <= '0;
         pad_ff      <= 1'b0;
         last_blk_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         round_ff    <= round_in;
         idx_ff      <= idx_in;
         pad_ff      <= pad_in;
         last_blk_ff <= last_blk_in;
      end
   end

   // Output register: holds one beat while the sink stalls.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   assign rsp_data_in.digest_word = hash[idx_ff];
   assign rsp_data_in.word_index  = idx_ff;
   assign rsp_data_in.last_word   = (idx_ff == DIGEST_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sha_checker.sv =====
// ---------------------------------------------------------------------------
// sha_checker
// Port-level checks on the hasher, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sha256_stream_hasher_top_macros.svh"

module sha_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire sha_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   `SHA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled digest beat changed")
   `SHA_ASSERT(a_last_marks_h7, rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == DIGEST_LAST)), "last_word does not match word_index")
   `SHA_ASSERT_NEXT(a_finish_busy, req_valid && !req_stall && req_data.action == ACT_FINISH, req_stall, "input taken right after finish")
   `SHA_ASSERT(a_digest_blocks_input, rsp_valid && !rsp_data.last_word |-> req_stall, "input open while digest is still draining")

endmodule

bind sha256_stream_hasher_top sha_checker u_sha_checker (.*);

`default_nettype wire
